// ----- hdl/cba_pkg.sv -----
// Shared constants and types of the contiguous block allocator.
`default_nettype none

package cba_pkg;

  // Number of entries in the pool, one in-use bit each.
  localparam int POOL_ENTRIES = 256;

  // Entry index width, and a width that can hold the entry count itself.
  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

  // Fixed field widths of the request and response words.
  localparam int OP_W    = 1;
  localparam int LEN_W   = 9;
  localparam int START_W = 8;

  // Width for range bounds and compares; holds every sum of a start and a length.
  localparam int WIDE_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  // Scan token that travels one cell per cycle along the row.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [CNT_W-1:0] run;
    logic [IDX_W-1:0] start;
  } token_t;

  // Range write broadcast to all cells: entries in [lo, hi) take the value set.
  typedef struct packed {
    logic              en;
    logic              set;
    logic [WIDE_W-1:0] lo;
    logic [WIDE_W-1:0] hi;
  } update_t;

endpackage

`default_nettype wire

// ----- hdl/cba_req_if.sv -----
// Request channel of the allocator: valid, ready and the request word.
`default_nettype none

interface cba_req_if;
  logic                        valid;
  logic                        ready;
  logic [cba_pkg::OP_W-1:0]    opcode;
  logic [cba_pkg::LEN_W-1:0]   run_length;
  logic [cba_pkg::START_W-1:0] release_start;

  modport source (output valid, opcode, run_length, release_start, input ready);
  modport sink   (input valid, opcode, run_length, release_start, output ready);
endinterface

`default_nettype wire

// ----- hdl/cba_rsp_if.sv -----
// Response channel of the allocator: valid, ready and the response word.
`default_nettype none

interface cba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [cba_pkg::START_W-1:0] start_index;

  modport source (output valid, success, start_index, input ready);
  modport sink   (input valid, success, start_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/cba_cell.sv -----
// One pool entry: its in-use bit and one stage of the scan token pipeline.
`default_nettype none

module cba_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [cba_pkg::IDX_W-1:0]   idx,
  input  wire logic [cba_pkg::WIDE_W-1:0]  target,
  input  wire cba_pkg::token_t             tok_in,
  input  wire cba_pkg::update_t            upd,
  output cba_pkg::token_t                  tok_out
);

  logic                       in_use;
  cba_pkg::token_t            tok_next;
  logic [cba_pkg::CNT_W-1:0]  run_next;
  logic [cba_pkg::WIDE_W-1:0] idx_w;
  logic                       in_range;

  assign idx_w    = {{(cba_pkg::WIDE_W - cba_pkg::IDX_W){1'b0}}, idx};
  assign in_range = (idx_w >= upd.lo) && (idx_w < upd.hi);

  // A used entry restarts the free run just past itself; a free entry extends it.
  always_comb begin
    tok_next = tok_in;
    run_next = tok_in.run + 1'b1;
    if (tok_in.valid && !tok_in.found) begin
      if (in_use) begin
        tok_next.run   = '0;
        tok_next.start = idx + 1'b1;
      end else begin
        tok_next.run = run_next;
        if (tok_in.run == '0) begin
          tok_next.start = idx;
        end
        tok_next.found =
          ({{(cba_pkg::WIDE_W - cba_pkg::CNT_W){1'b0}}, run_next} == target);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
    end else if (upd.en && in_range) begin
      in_use <= upd.set;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cba_cell_row.sv -----
// Row of allocator cells chained from entry 0 to the last entry.
`default_nettype none

module cba_cell_row (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [cba_pkg::WIDE_W-1:0] target,
  input  wire cba_pkg::token_t            tok_in,
  input  wire cba_pkg::update_t           upd,
  output cba_pkg::token_t                 tok_out
);

  cba_pkg::token_t chain [cba_pkg::POOL_ENTRIES+1];

  assign chain[0] = tok_in;

  for (genvar g = 0; g < cba_pkg::POOL_ENTRIES; g++) begin : g_cell
    cba_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (cba_pkg::IDX_W'(g)),
      .target  (target),
      .tok_in  (chain[g]),
      .upd     (upd),
      .tok_out (chain[g+1])
    );
  end

  assign tok_out = chain[cba_pkg::POOL_ENTRIES];

endmodule

`default_nettype wire

// ----- hdl/contiguous_block_allocator.sv -----
// Top level of the first-fit contiguous block allocator.
// Flow: a release word goes to the staged result (ST_HOLD) and then the output register;
// an allocate word first sends the scan token across the cell row, then does the same.
// Throughput: one word at a time; a new word is taken in the cycle after the previous
// result moves to the output register, which it does only once that register is free.
// Reset: synchronous; every in-use bit is cleared in the reset cycle itself.
`default_nettype none

module contiguous_block_allocator (
  input wire logic clk,
  input wire logic rst,
  cba_req_if.sink  req,
  cba_rsp_if.source rsp
);

  // Sequencer states: waiting for a word, scan token in flight, result staged.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [cba_pkg::WIDE_W-1:0] POOL_W = cba_pkg::WIDE_W'(cba_pkg::POOL_ENTRIES);

  logic [1:0]                   state;
  logic [cba_pkg::LEN_W-1:0]    len_q;
  logic                         res_ok;
  logic [cba_pkg::START_W-1:0]  res_start;

  cba_pkg::token_t              tok_in;
  cba_pkg::token_t              tok_last;
  cba_pkg::update_t             upd;

  logic [cba_pkg::LEN_W-1:0]    len_sel;
  logic [cba_pkg::WIDE_W-1:0]   target;
  logic [cba_pkg::WIDE_W-1:0]   rstart_w;
  logic [cba_pkg::WIDE_W-1:0]   rel_sum;
  logic [cba_pkg::WIDE_W-1:0]   rel_hi;
  logic [cba_pkg::WIDE_W-1:0]   found_lo;
  logic                         rel_ok;
  logic                         accept;
  logic                         out_free;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // The run length the cells compare against: taken straight from the request
  // in the cycle the token is launched, and from the latched copy afterwards.
  // A zero-length request looks for a run of one, which is the first free entry.
  assign len_sel = (state == ST_IDLE) ? req.run_length : len_q;
  assign target  = (len_sel == '0) ? cba_pkg::WIDE_W'(1)
                                   : {{(cba_pkg::WIDE_W - cba_pkg::LEN_W){1'b0}}, len_sel};

  // Release bounds, with the end clipped to the pool size.
  assign rstart_w = {{(cba_pkg::WIDE_W - cba_pkg::START_W){1'b0}}, req.release_start};
  assign rel_sum  = rstart_w + {{(cba_pkg::WIDE_W - cba_pkg::LEN_W){1'b0}}, req.run_length};
  assign rel_hi   = (rel_sum > POOL_W) ? POOL_W : rel_sum;
  assign rel_ok   = (rstart_w < POOL_W);

  assign found_lo = {{(cba_pkg::WIDE_W - cba_pkg::IDX_W){1'b0}}, tok_last.start};

  // Launch a fresh token into cell 0 when an allocate word is accepted.
  always_comb begin
    tok_in       = '0;
    tok_in.valid = accept && (req.opcode == cba_pkg::OP_ALLOC);
  end

  // The single range write: a release clears its run on acceptance, and a
  // successful allocate marks its run once the token leaves the last cell.
  always_comb begin
    upd = '0;
    if (accept && (req.opcode == cba_pkg::OP_RELEASE) && rel_ok) begin
      upd.en  = 1'b1;
      upd.set = 1'b0;
      upd.lo  = rstart_w;
      upd.hi  = rel_hi;
    end else if ((state == ST_SCAN) && tok_last.valid && tok_last.found) begin
      upd.en  = 1'b1;
      upd.set = 1'b1;
      upd.lo  = found_lo;
      upd.hi  = found_lo + {{(cba_pkg::WIDE_W - cba_pkg::LEN_W){1'b0}}, len_q};
    end
  end

  cba_cell_row u_row (
    .clk     (clk),
    .rst     (rst),
    .target  (target),
    .tok_in  (tok_in),
    .upd     (upd),
    .tok_out (tok_last)
  );

  // Sequencer and result staging.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            len_q <= req.run_length;
            if (req.opcode == cba_pkg::OP_RELEASE) begin
              res_ok    <= rel_ok;
              res_start <= rel_ok ? req.release_start : '0;
              state     <= ST_HOLD;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tok_last.valid) begin
            res_ok    <= tok_last.found;
            res_start <= tok_last.found ? cba_pkg::START_W'(tok_last.start) : '0;
            state     <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: the staged result moves here as soon as the slot is free,
  // so a finished word can wait for the sink while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == ST_HOLD) && out_free) begin
      rsp.valid       <= 1'b1;
      rsp.success     <= res_ok;
      rsp.start_index <= res_start;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // The token only comes out of the row while the sequencer waits for it.
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> (state == ST_SCAN))
    else $error("scan token left the row outside a scan");

  // An accepted allocate word always starts a scan in the next cycle.
  a_alloc_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.opcode == cba_pkg::OP_ALLOC)) |=> (state == ST_SCAN))
    else $error("allocate word did not start a scan");

  // Every range write stays inside the pool and is well ordered.
  a_range_in_pool: assert property (@(posedge clk) disable iff (rst)
    upd.en |-> ((upd.lo <= upd.hi) && (upd.hi <= POOL_W)))
    else $error("range write outside the pool");

  // The bitmap is not touched while a token is still in flight.
  a_no_write_mid_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && !tok_last.valid) |-> !upd.en)
    else $error("bitmap written during a scan");
`endif

endmodule

`default_nettype wire

// ----- sim/contiguous_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit contiguous block allocator.

module contiguous_block_allocator_tb;

  // The limit covers a full allocate scan across the cell row plus the longest idle
  // bursts on both sides, several times over.
  localparam int WATCHDOG_LIMIT = 8 * (cba_pkg::POOL_ENTRIES + 40);
  localparam int MAX_REPORTS = 10;

  // One response word as the allocator reports it.
  typedef struct packed {
    logic                        success;
    logic [cba_pkg::START_W-1:0] start_index;
  } grant_t;

  logic clk;
  logic rst;

  cba_req_if req ();
  cba_rsp_if rsp ();

  contiguous_block_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Our own copy of the in-use bitmap, updated as each request word is accepted.
  bit [cba_pkg::POOL_ENTRIES-1:0] pool_used;

  // Responses still owed by the block, oldest first.
  grant_t expected_grants[$];

  // Idling is enabled per side; the last part of the run turns both off.
  bit sender_idles;
  bit receiver_idles;

  int error_count;
  int result_count;
  int alloc_grants;
  int alloc_refusals;
  int release_words;
  int peak_fill;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Number of entries currently marked in use in our copy of the map.
  function automatic int pool_fill();
    int n;
    n = 0;
    for (int i = 0; i < cba_pkg::POOL_ENTRIES; i++) begin
      n += pool_used[i];
    end
    return n;
  endfunction

  // Applies one accepted request word to the bitmap copy and returns the
  // response the block must give for it.
  function automatic grant_t model_request(input logic [cba_pkg::OP_W-1:0] op,
                                           input logic [cba_pkg::LEN_W-1:0] len,
                                           input logic [cba_pkg::START_W-1:0] rstart);
    grant_t res;
    int pos;
    int k;
    int stop;
    bit blocked;
    res = '0;
    if (op == cba_pkg::OP_RELEASE) begin
      release_words++;
      if (int'(rstart) >= cba_pkg::POOL_ENTRIES) begin
        return res;
      end
      // The cleared run is clipped at the last entry of the pool.
      stop = int'(rstart) + int'(len);
      if (stop > cba_pkg::POOL_ENTRIES) begin
        stop = cba_pkg::POOL_ENTRIES;
      end
      for (k = int'(rstart); k < stop; k++) begin
        pool_used[k] = 1'b0;
      end
      res.success = 1'b1;
      res.start_index = rstart;
      return res;
    end
    // First-fit scan. Once the first free candidate cannot hold the run before
    // the pool end, no later start can either, so the request is refused.
    pos = 0;
    while (pos < cba_pkg::POOL_ENTRIES) begin
      if (pool_used[pos]) begin
        pos++;
        continue;
      end
      stop = pos + int'(len);
      if (stop > cba_pkg::POOL_ENTRIES) begin
        break;
      end
      blocked = 1'b0;
      for (k = pos + 1; k < stop; k++) begin
        if (pool_used[k]) begin
          blocked = 1'b1;
          break;
        end
      end
      if (blocked) begin
        // Resume just past the entry that blocked the run.
        pos = k + 1;
        continue;
      end
      for (k = pos; k < stop; k++) begin
        pool_used[k] = 1'b1;
      end
      res.success = 1'b1;
      res.start_index = pos[cba_pkg::START_W-1:0];
      alloc_grants++;
      if (pool_fill() > peak_fill) begin
        peak_fill = pool_fill();
      end
      return res;
    end
    alloc_refusals++;
    return res;
  endfunction

  // Drives one request word and holds it until the block takes it. Called
  // right after a rising edge; returns at the edge where the word was taken,
  // with valid still high so a following word can go out back to back.
  task automatic issue_request(input logic [cba_pkg::OP_W-1:0] op,
                               input logic [cba_pkg::LEN_W-1:0] len,
                               input logic [cba_pkg::START_W-1:0] rstart);
    int gap;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.opcode        <= op;
    req.run_length    <= len;
    req.release_start <= rstart;
    do @(posedge clk); while (!(req.valid && req.ready));
    expected_grants.push_back(model_request(op, len, rstart));
  endtask

  task automatic allocate(input int len);
    issue_request(cba_pkg::OP_ALLOC, cba_pkg::LEN_W'(len),
                  cba_pkg::START_W'($urandom_range(0, 255)));
  endtask

  task automatic release_run(input int rstart, input int len);
    issue_request(cba_pkg::OP_RELEASE, cba_pkg::LEN_W'(len), cba_pkg::START_W'(rstart));
  endtask

  // Mostly short runs, now and then a long one or one that cannot fit at all.
  function automatic int pick_alloc_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 0;
    if (sel < 85) return $urandom_range(1, 16);
    if (sel < 95) return $urandom_range(17, 80);
    if (sel < 98) return $urandom_range(81, 256);
    return $urandom_range(257, 511);
  endfunction

  function automatic int pick_release_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 16);
    if (sel < 90) return $urandom_range(17, 64);
    if (sel < 96) return 0;
    return $urandom_range(65, 511);
  endfunction

  // One random word whose mix leans toward release as the pool fills up, so
  // the map keeps moving between sparse, fragmented and nearly full.
  task automatic random_word();
    int fill;
    int alloc_pct;
    fill = pool_fill();
    alloc_pct = (fill > 200) ? 30 : (fill < 60) ? 75 : 55;
    if ($urandom_range(0, 99) < alloc_pct) begin
      allocate(pick_alloc_len());
    end else begin
      release_run($urandom_range(0, 255), pick_release_len());
    end
  endtask

  // Lowers valid and waits until every owed response has come back.
  task automatic wait_for_drain();
    req.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
  endtask

  // Extremes of each field and the corner cases of the scan and the release.
  task automatic test_directed();
    allocate(0);                // empty pool: first free entry is 0, nothing marked
    allocate(256);              // whole pool in one run
    allocate(1);                // pool full
    allocate(0);                // zero length on a full pool is refused too
    release_run(255, 511);      // release past the pool end is clipped
    allocate(1);                // lands on the last entry
    release_run(0, 256);        // everything free again
    allocate(257);              // longer than the pool
    allocate(511);
    allocate(10);               // 0..9
    allocate(5);                // 10..14
    release_run(3, 2);          // hole of two at 3..4
    allocate(3);                // blocked by entry 5, goes to 15
    allocate(2);                // fits the hole at 3
    release_run(100, 0);        // zero-length release only echoes the start
    release_run(200, 10);       // entries already free stay free
    release_run(170, 85);       // bit patterns on start and length
    release_run(85, 170);
    release_run(0, 256);
    allocate(250);              // 0..249
    allocate(10);               // first free entry too close to the end
    allocate(6);                // exactly the tail 250..255
    release_run(255, 1);
    allocate(0);                // first free is the last entry
    release_run(0, 256);
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      random_word();
    end
  endtask

  // Fills the pool with small runs, then keeps punching short holes and
  // asking for runs a little longer than the holes, so most scans are blocked
  // several times before they fit or give up.
  task automatic test_fragmented_pool(input int count);
    release_run(0, 256);
    while (pool_fill() < 200) begin
      allocate($urandom_range(1, 4));
    end
    for (int i = 0; i < count; i++) begin
      if (i % 3 == 0) begin
        release_run($urandom_range(0, 255), $urandom_range(1, 3));
      end else begin
        allocate($urandom_range(1, 6));
      end
    end
  endtask

  // Back-to-back words with both sides always ready.
  task automatic test_full_rate(input int count);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    for (int i = 0; i < count; i++) begin
      random_word();
    end
  endtask

  // Receiver: ready drops in random bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Compares each response word with the oldest owed one, and counts cycles
  // in which neither channel moves a word.
  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        result_count++;
        if (expected_grants.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Unexpected response word: success=%0b start_index=%0d",
                     rsp.success, rsp.start_index);
          end
        end else begin
          want = expected_grants.pop_front();
          if (rsp.success !== want.success || rsp.start_index !== want.start_index) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("Response %0d wrong: expected success=%0b start_index=%0d,",
                       result_count, want.success, want.start_index);
              $display("  got success=%0b start_index=%0d",
                       rsp.success, rsp.start_index);
            end
          end
        end
      end
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no word moved for %0d cycles, %0d responses owed",
                   quiet_cycles, expected_grants.size());
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    pool_used = '0;
    error_count = 0;
    result_count = 0;
    alloc_grants = 0;
    alloc_refusals = 0;
    release_words = 0;
    peak_fill = 0;
    quiet_cycles = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.opcode <= cba_pkg::OP_ALLOC;
    req.run_length <= '0;
    req.release_start <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(600);
    test_fragmented_pool(250);
    test_full_rate(230);

    wait_for_drain();
    // A spurious word would show up within one scan time.
    repeat (cba_pkg::POOL_ENTRIES + 8) @(posedge clk);

    $display("Ran %0d allocate words (%0d granted, %0d refused) and %0d release words.",
             alloc_grants + alloc_refusals, alloc_grants, alloc_refusals, release_words);
    $display("Checked %0d responses; the map peaked at %0d of %0d entries in use.",
             result_count, peak_fill, cba_pkg::POOL_ENTRIES);
    if (error_count == 0 && expected_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d responses never arrived", error_count,
               expected_grants.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
